>>> hdl/alfl_pkg.sv
`timescale 1ns / 1ps
// Package for the array linked list with free list: field widths, request codes,
// microcode word layout, the control store and the dispatch table.
// Depends on nothing; used by alfl_seq and the top level.
package alfl_pkg;

  localparam int KEY_W  = 16;
  localparam int PAY_W  = 32;
  localparam int RANK_W = 7;
  localparam int SLOT_W = 7;
  localparam int UPC_W  = 4;

  localparam logic [RANK_W-1:0] RANK_MAX  = 7'd127;
  localparam logic [SLOT_W-1:0] SLOT_NONE = 7'h7F;

  typedef logic [1:0]       op_t;
  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [1:0]       rsel_t;
  typedef logic [3:0]       act_t;
  typedef logic [1:0]       cond_t;

  // Request codes.
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;
  localparam op_t OP_RANK   = 2'd3;

  // Read address source for the slot memories.
  localparam rsel_t RS_HEAD = 2'd0;
  localparam rsel_t RS_FREE = 2'd1;
  localparam rsel_t RS_LINK = 2'd2;

  // Datapath actions.
  localparam act_t ACT_NONE        = 4'd0;
  localparam act_t ACT_ACCEPT      = 4'd1;
  localparam act_t ACT_INSERT      = 4'd2;
  localparam act_t ACT_WALK_INIT   = 4'd3;
  localparam act_t ACT_SCAN_SEARCH = 4'd4;
  localparam act_t ACT_SCAN_REMOVE = 4'd5;
  localparam act_t ACT_SCAN_RANK   = 4'd6;
  localparam act_t ACT_UNLINK      = 4'd7;
  localparam act_t ACT_FREE        = 4'd8;

  // Sequencing conditions.
  localparam cond_t COND_NEXT     = 2'd0;
  localparam cond_t COND_JUMP     = 2'd1;
  localparam cond_t COND_DISPATCH = 2'd2;
  localparam cond_t COND_SCAN     = 2'd3;

  // Control store addresses.
  localparam upc_t UPC_IDLE       = 4'd0;
  localparam upc_t UPC_INS_RD     = 4'd1;
  localparam upc_t UPC_INS_DO     = 4'd2;
  localparam upc_t UPC_SRCH_INIT  = 4'd3;
  localparam upc_t UPC_SRCH_SCAN  = 4'd4;
  localparam upc_t UPC_REM_INIT   = 4'd5;
  localparam upc_t UPC_REM_SCAN   = 4'd6;
  localparam upc_t UPC_REM_UNLINK = 4'd7;
  localparam upc_t UPC_REM_FREE   = 4'd8;
  localparam upc_t UPC_RNK_INIT   = 4'd9;
  localparam upc_t UPC_RNK_SCAN   = 4'd10;

  typedef struct packed {
    rsel_t rsel;
    act_t  act;
    cond_t cond;
    logic  match;
    upc_t  tgt;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic scan_end;
    logic scan_hit;
  } seq_stat_t;

  function automatic uword_t mk_uw(input rsel_t rsel, input act_t act, input cond_t cond,
                                   input logic match, input upc_t tgt);
    uword_t w;
    w.rsel  = rsel;
    w.act   = act;
    w.cond  = cond;
    w.match = match;
    w.tgt   = tgt;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    unique case (a)
      UPC_IDLE:       w = mk_uw(RS_HEAD, ACT_ACCEPT, COND_DISPATCH, 1'b0, UPC_IDLE);
      UPC_INS_RD:     w = mk_uw(RS_FREE, ACT_NONE, COND_NEXT, 1'b0, UPC_IDLE);
      UPC_INS_DO:     w = mk_uw(RS_HEAD, ACT_INSERT, COND_JUMP, 1'b0, UPC_IDLE);
      UPC_SRCH_INIT:  w = mk_uw(RS_HEAD, ACT_WALK_INIT, COND_NEXT, 1'b0, UPC_IDLE);
      UPC_SRCH_SCAN:  w = mk_uw(RS_LINK, ACT_SCAN_SEARCH, COND_SCAN, 1'b1, UPC_IDLE);
      UPC_REM_INIT:   w = mk_uw(RS_HEAD, ACT_WALK_INIT, COND_NEXT, 1'b0, UPC_IDLE);
      UPC_REM_SCAN:   w = mk_uw(RS_LINK, ACT_SCAN_REMOVE, COND_SCAN, 1'b1, UPC_REM_UNLINK);
      UPC_REM_UNLINK: w = mk_uw(RS_HEAD, ACT_UNLINK, COND_NEXT, 1'b0, UPC_IDLE);
      UPC_REM_FREE:   w = mk_uw(RS_HEAD, ACT_FREE, COND_JUMP, 1'b0, UPC_IDLE);
      UPC_RNK_INIT:   w = mk_uw(RS_HEAD, ACT_WALK_INIT, COND_NEXT, 1'b0, UPC_IDLE);
      UPC_RNK_SCAN:   w = mk_uw(RS_LINK, ACT_SCAN_RANK, COND_SCAN, 1'b0, UPC_IDLE);
      default:        w = mk_uw(RS_HEAD, ACT_NONE, COND_JUMP, 1'b0, UPC_IDLE);
    endcase
    return w;
  endfunction

  // Entry point of each request's program.
  function automatic upc_t dispatch(input op_t op);
    upc_t t;
    unique case (op)
      OP_INSERT: t = UPC_INS_RD;
      OP_SEARCH: t = UPC_SRCH_INIT;
      OP_REMOVE: t = UPC_REM_INIT;
      OP_RANK:   t = UPC_RNK_INIT;
      default:   t = UPC_IDLE;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/alfl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module alfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/alfl_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on alfl_pkg.
module alfl_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  alfl_pkg::op_t         op,
  input  alfl_pkg::seq_stat_t   stat,
  output alfl_pkg::uword_t      uw,
  output logic                  busy
);
  import alfl_pkg::*;

  upc_t upc_r, upc_nxt;

  assign uw   = ucode(upc_r);
  assign busy = (upc_r != UPC_IDLE);

  always_comb begin
    upc_nxt = upc_r;
    unique case (uw.cond)
      COND_NEXT:     upc_nxt = upc_t'(upc_r + 1'b1);
      COND_JUMP:     upc_nxt = uw.tgt;
      COND_DISPATCH: upc_nxt = stat.accept ? dispatch(op) : upc_r;
      COND_SCAN: begin
        if (stat.scan_end) begin
          upc_nxt = UPC_IDLE;
        end else if (uw.match && stat.scan_hit) begin
          upc_nxt = uw.tgt;
        end
      end
      default:       upc_nxt = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

>>> hdl/array_linked_list_with_free_list.sv
`timescale 1ns / 1ps
// Top level of the array linked list with free list: slot memories and datapath,
// driven by the microcode sequencer. Depends on alfl_pkg, alfl_ram and alfl_seq.
//
// A pool of SLOTS slots holds a singly linked list of keyed entries and a free
// list threaded through the same next links. A request is taken when start is
// high and busy is low; its single result appears on the out_ ports for exactly
// one cycle, marked by out_valid, and the receiver cannot hold it off. Search,
// remove and rank walk the list one link per clock, limited by the registered
// read port of the link memory; remove adds an unlink and a free step on a hit.
// The result appears in the first cycle with busy low, and a new request may be
// taken in that same cycle. Reset needs no clearing pass: the initial free chain
// is supplied by a fill count, and slots never allocated read their link as the
// next slot number. Slot numbers above 127 are reported in their low seven bits;
// -1 (all ones) means no slot. Stored ranks saturate at 127.
module array_linked_list_with_free_list #(
  parameter int SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_key,
  input  logic [31:0]        in_payload,
  output logic               out_valid,
  output logic               out_ok,
  output logic signed [6:0]  out_slot,
  output logic [6:0]         out_rank,
  output logic [31:0]        out_found_payload
);
  import alfl_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // Sequencer interface.
  uword_t    uw;
  seq_stat_t stat;

  // Architectural pointers and the fill count of slots ever allocated.
  logic [PW-1:0] list_head_r, list_head_nxt;
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] fill_r, fill_nxt;

  // Walk registers.
  logic [PW-1:0]     cur_r, cur_nxt;
  logic [PW-1:0]     prev_r, prev_nxt;
  logic [PW-1:0]     steps_r, steps_nxt;
  logic [RANK_W-1:0] pos_r, pos_nxt;
  logic [PW-1:0]     lnk_r, lnk_nxt;
  logic [PW-1:0]     ra_q_r;

  // Latched request.
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;

  // Result registers.
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic [PAY_W-1:0]  out_pay_r, out_pay_nxt;

  // Memory ports.
  logic [PW-1:0]     ra;
  logic [AW-1:0]     mem_ra;
  logic [PW-1:0]     link_rd;
  logic [KEY_W-1:0]  key_rd;
  logic [PAY_W-1:0]  pay_rd;
  logic [RANK_W-1:0] rank_rd;

  logic              lk_we;
  logic [PW-1:0]     lk_wa;
  logic [PW-1:0]     lk_wd;
  logic              ent_we;
  logic              rk_we;
  logic [PW-1:0]     rk_wa;
  logic [RANK_W-1:0] rk_wd;

  // Walk status.
  logic          accept;
  logic [PW-1:0] lnk_fix;
  logic          cur_is_slot;
  logic          scan_end;
  logic          scan_hit;
  logic          free_ok;

  // Result staging.
  logic              emit;
  logic              emit_ok;
  logic [PW-1:0]     emit_slot;
  logic [RANK_W-1:0] emit_rank;
  logic [PAY_W-1:0]  emit_pay;
  logic [PW+SLOT_W-1:0] emit_slot_ext;

  assign accept = start && !busy;

  // A slot at or above the fill count was never allocated, so its link is read
  // as the reset chain value: the next slot number.
  assign lnk_fix = (ra_q_r >= fill_r) ? PW'(ra_q_r + 1'b1) : link_rd;

  assign cur_is_slot = (cur_r < NIL);
  assign scan_end    = !cur_is_slot || (steps_r == NIL);
  assign scan_hit    = !scan_end && (key_rd == key_r);
  assign free_ok     = (free_head_r < NIL);

  assign stat.accept   = accept;
  assign stat.scan_end = scan_end;
  assign stat.scan_hit = scan_hit;

  alfl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (in_operation),
    .stat  (stat),
    .uw    (uw),
    .busy  (busy)
  );

  // Read address for all four memories; they are read in lock step.
  always_comb begin
    unique case (uw.rsel)
      RS_HEAD: ra = list_head_r;
      RS_FREE: ra = free_head_r;
      RS_LINK: ra = lnk_fix;
      default: ra = list_head_r;
    endcase
  end

  assign mem_ra = ra[AW-1:0];

  alfl_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_wa[AW-1:0]),
    .wdata (lk_wd),
    .raddr (mem_ra),
    .rdata (link_rd)
  );

  alfl_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (free_head_r[AW-1:0]),
    .wdata (key_r),
    .raddr (mem_ra),
    .rdata (key_rd)
  );

  alfl_ram #(.WIDTH(PAY_W), .DEPTH(SLOTS)) u_pay_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (free_head_r[AW-1:0]),
    .wdata (pay_r),
    .raddr (mem_ra),
    .rdata (pay_rd)
  );

  alfl_ram #(.WIDTH(RANK_W), .DEPTH(SLOTS)) u_rank_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_wa[AW-1:0]),
    .wdata (rk_wd),
    .raddr (mem_ra),
    .rdata (rank_rd)
  );

  // Datapath: each microcode action updates pointers, memories and the result.
  always_comb begin
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    pos_nxt       = pos_r;
    lnk_nxt       = lnk_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;

    lk_we  = 1'b0;
    lk_wa  = free_head_r;
    lk_wd  = list_head_r;
    ent_we = 1'b0;
    rk_we  = 1'b0;
    rk_wa  = free_head_r;
    rk_wd  = '0;

    emit      = 1'b0;
    emit_ok   = 1'b0;
    emit_slot = NIL;
    emit_rank = '0;
    emit_pay  = '0;

    case (uw.act)
      ACT_ACCEPT: begin
        if (accept) begin
          key_nxt = in_key;
          pay_nxt = in_payload;
        end
      end
      ACT_INSERT: begin
        emit = 1'b1;
        if (free_ok) begin
          // Pop the free head, fill it and push it at the list head.
          lk_we         = 1'b1;
          ent_we        = 1'b1;
          rk_we         = 1'b1;
          free_head_nxt = lnk_fix;
          list_head_nxt = free_head_r;
          if (free_head_r == fill_r) begin
            fill_nxt = PW'(fill_r + 1'b1);
          end
          emit_ok   = 1'b1;
          emit_slot = free_head_r;
        end
      end
      ACT_WALK_INIT: begin
        cur_nxt   = list_head_r;
        prev_nxt  = NIL;
        steps_nxt = '0;
        pos_nxt   = RANK_W'(1);
      end
      ACT_SCAN_SEARCH: begin
        if (scan_end) begin
          emit = 1'b1;
        end else if (scan_hit) begin
          emit      = 1'b1;
          emit_ok   = 1'b1;
          emit_slot = cur_r;
          emit_rank = rank_rd;
          emit_pay  = pay_rd;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = lnk_fix;
          steps_nxt = PW'(steps_r + 1'b1);
        end
      end
      ACT_SCAN_REMOVE: begin
        if (scan_end) begin
          emit = 1'b1;
        end else if (scan_hit) begin
          lnk_nxt = lnk_fix;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = lnk_fix;
          steps_nxt = PW'(steps_r + 1'b1);
        end
      end
      ACT_SCAN_RANK: begin
        if (scan_end) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end else begin
          rk_we     = 1'b1;
          rk_wa     = cur_r;
          rk_wd     = pos_r;
          pos_nxt   = (pos_r == RANK_MAX) ? RANK_MAX : RANK_W'(pos_r + 1'b1);
          prev_nxt  = cur_r;
          cur_nxt   = lnk_fix;
          steps_nxt = PW'(steps_r + 1'b1);
        end
      end
      ACT_UNLINK: begin
        // Bypass the matched slot, either from its predecessor or from the head.
        if (prev_r < NIL) begin
          lk_we = 1'b1;
          lk_wa = prev_r;
          lk_wd = lnk_r;
        end else begin
          list_head_nxt = lnk_r;
        end
      end
      ACT_FREE: begin
        lk_we         = 1'b1;
        lk_wa         = cur_r;
        lk_wd         = free_head_r;
        free_head_nxt = cur_r;
        emit          = 1'b1;
        emit_ok       = 1'b1;
        emit_slot     = cur_r;
      end
      default: begin
      end
    endcase
  end

  // Slot numbers go out in their low seven bits; no slot goes out as all ones.
  assign emit_slot_ext = {{SLOT_W{1'b0}}, emit_slot};

  always_comb begin
    out_valid_nxt = emit;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    out_rank_nxt  = out_rank_r;
    out_pay_nxt   = out_pay_r;
    if (emit) begin
      out_ok_nxt   = emit_ok;
      out_slot_nxt = (emit_slot < NIL) ? emit_slot_ext[SLOT_W-1:0] : SLOT_NONE;
      out_rank_nxt = emit_rank;
      out_pay_nxt  = emit_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_head_r <= NIL;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    steps_r    <= steps_nxt;
    pos_r      <= pos_nxt;
    lnk_r      <= lnk_nxt;
    ra_q_r     <= ra;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    out_ok_r   <= out_ok_nxt;
    out_slot_r <= out_slot_nxt;
    out_rank_r <= out_rank_nxt;
    out_pay_r  <= out_pay_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_slot          = out_slot_r;
  assign out_rank          = out_rank_r;
  assign out_found_payload = out_pay_r;

endmodule

>>> hdl/alfl_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the array linked list with free list, and its bind.
// Depends on the top level array_linked_list_with_free_list.
module alfl_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic              out_ok,
  input logic signed [6:0] out_slot,
  input logic [6:0]        out_rank,
  input logic [31:0]       out_found_payload
);

  // A taken request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but block not busy next cycle");

  // A result is shown only once its request has finished.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of a request");

  // Strobes never touch, since no request ends right after it is taken.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A failed request reports no slot and zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |->
      out_slot == 7'sh7F && out_rank == 7'd0 && out_found_payload == 32'd0)
    else $error("failed request with nonzero result fields");

endmodule

bind array_linked_list_with_free_list alfl_chk u_alfl_chk (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for array_linked_list_with_free_list: directed and random
// insert, search, remove and rank requests, each result checked against a slot-pool model.
// Depends on alfl_pkg and the RTL of the block.
module tb;
  import alfl_pkg::*;

  localparam int SLOTS        = 64;
  localparam int NO_SLOT      = SLOTS;      // end-of-chain marker inside the model
  localparam int CYCLE_LIMIT  = 1_000_000;  // far beyond the slowest correct run
  localparam int SETTLE_WAIT  = SLOTS + 16; // longest walk plus a margin

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } request_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [RANK_W-1:0] rank;
    logic [PAY_W-1:0]  payload;
  } outcome_t;

  // Every input has a known value from time zero.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [1:0]        in_operation = '0;
  logic [15:0]       in_key = '0;
  logic [31:0]       in_payload = '0;
  logic              busy;
  logic              out_valid;
  logic              out_ok;
  logic signed [6:0] out_slot;
  logic [6:0]        out_rank;
  logic [31:0]       out_found_payload;

  array_linked_list_with_free_list #(.SLOTS(SLOTS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_slot          (out_slot),
    .out_rank          (out_rank),
    .out_found_payload (out_found_payload)
  );

  always #1 clk = ~clk;

  // Model of the slot pool. Links hold a slot number or NO_SLOT. Both the entry
  // list and the free list are threaded through link_of, as in the block.
  int               link_of [SLOTS];
  logic [KEY_W-1:0] key_of [SLOTS];
  logic [PAY_W-1:0] payload_of [SLOTS];
  logic [RANK_W-1:0] rank_of [SLOTS];
  int               list_head;
  int               free_head;
  int               live_count;

  // Results predicted for accepted requests, oldest first.
  outcome_t pending_outcomes[$];
  bit       failed = 1'b0;
  int       sender_idle_pct = 0;
  bit       filling = 1'b1;

  // After reset every slot is chained into the free list in order.
  function automatic void clear_pool();
    for (int i = 0; i < SLOTS; i++) begin
      link_of[i] = i + 1;
      key_of[i] = '0;
      payload_of[i] = '0;
      rank_of[i] = '0;
    end
    list_head = NO_SLOT;
    free_head = 0;
    live_count = 0;
  endfunction

  // Walk from the head to the first matching key. prev returns the predecessor,
  // or NO_SLOT when the match is the head. The walk never exceeds SLOTS links.
  function automatic int find_first(input logic [KEY_W-1:0] k, output int prev);
    int cur;
    int steps;
    cur = list_head;
    prev = NO_SLOT;
    steps = 0;
    while (cur != NO_SLOT && steps < SLOTS) begin
      if (key_of[cur] == k) return cur;
      prev = cur;
      cur = link_of[cur];
      steps++;
    end
    prev = NO_SLOT;
    return NO_SLOT;
  endfunction

  // Applies one request to the model and returns the result the block must give.
  function automatic outcome_t apply_request(input request_t r);
    outcome_t o;
    int s;
    int prev;
    int cur;
    int pos;
    o.ok = 1'b0;
    o.slot = SLOT_NONE;
    o.rank = '0;
    o.payload = '0;
    case (r.op)
      OP_INSERT: begin
        // A full pool leaves everything unchanged and reports failure.
        if (free_head != NO_SLOT) begin
          s = free_head;
          free_head = link_of[s];
          key_of[s] = r.key;
          payload_of[s] = r.payload;
          rank_of[s] = '0;
          link_of[s] = list_head;
          list_head = s;
          live_count++;
          o.ok = 1'b1;
          o.slot = SLOT_W'(s);
        end
      end
      OP_SEARCH: begin
        s = find_first(r.key, prev);
        if (s != NO_SLOT) begin
          o.ok = 1'b1;
          o.slot = SLOT_W'(s);
          o.rank = rank_of[s];
          o.payload = payload_of[s];
        end
      end
      OP_REMOVE: begin
        // The freed slot keeps its key, payload and rank; only the links change.
        s = find_first(r.key, prev);
        if (s != NO_SLOT) begin
          if (prev != NO_SLOT) link_of[prev] = link_of[s];
          else list_head = link_of[s];
          link_of[s] = free_head;
          free_head = s;
          live_count--;
          o.ok = 1'b1;
          o.slot = SLOT_W'(s);
        end
      end
      OP_RANK: begin
        cur = list_head;
        pos = 1;
        while (cur != NO_SLOT && pos <= SLOTS) begin
          rank_of[cur] = (pos < RANK_MAX) ? RANK_W'(pos) : RANK_MAX;
          pos++;
          cur = link_of[cur];
        end
        o.ok = 1'b1;
      end
    endcase
    return o;
  endfunction

  function automatic request_t make_request(input op_t op, input logic [KEY_W-1:0] k,
                                            input logic [PAY_W-1:0] p);
    request_t r;
    r.op = op;
    r.key = k;
    r.payload = p;
    return r;
  endfunction

  // Sends one request. Before it the sender may idle for a random number of
  // cycles; start then stays high until an edge sees busy low, which is the
  // edge that takes the request. The prediction is made at that edge.
  task automatic issue_request(input request_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= r.op;
    in_key <= r.key;
    in_payload <= r.payload;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(apply_request(r));
  endtask

  // Every result is taken in the one cycle that out_valid marks and compared
  // field by field with the oldest prediction.
  always @(posedge clk) begin : check_outcomes
    outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        $error("result arrived with no request outstanding");
        failed = 1'b1;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          failed = 1'b1;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", $signed(want.slot), out_slot);
          failed = 1'b1;
        end
        if (out_rank !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, out_rank);
          failed = 1'b1;
        end
        if (out_found_payload !== want.payload) begin
          $error("found_payload: expected %h, got %h", want.payload, out_found_payload);
          failed = 1'b1;
        end
      end
    end
  end

  // Search, remove and rank on an empty list: misses, and a rank with nothing
  // to number.
  task automatic test_empty_list();
    issue_request(make_request(OP_SEARCH, 16'h1234, 32'h0));
    issue_request(make_request(OP_REMOVE, 16'h1234, 32'h0));
    issue_request(make_request(OP_RANK, 16'h0000, 32'hFFFF_FFFF));
  endtask

  // Extreme keys and payloads, unranked and ranked hits, and a duplicate key
  // where the newest entry (nearest the head) must win.
  task automatic test_insert_search_rank();
    issue_request(make_request(OP_INSERT, 16'h0000, 32'h0000_0000));
    issue_request(make_request(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
    issue_request(make_request(OP_INSERT, 16'h5555, 32'hAAAA_AAAA));
    issue_request(make_request(OP_INSERT, 16'hAAAA, 32'h5555_5555));
    issue_request(make_request(OP_SEARCH, 16'hFFFF, 32'h0));
    issue_request(make_request(OP_RANK, 16'h0, 32'h0));
    issue_request(make_request(OP_SEARCH, 16'h0000, 32'h0));
    issue_request(make_request(OP_SEARCH, 16'hAAAA, 32'h0));
    issue_request(make_request(OP_INSERT, 16'hAAAA, 32'h1234_5678));
    issue_request(make_request(OP_SEARCH, 16'hAAAA, 32'h0));
  endtask

  // Removal in the middle, at the head and at the tail, a repeated removal that
  // misses, and reuse of a freed slot by the next insert.
  task automatic test_remove_cases();
    issue_request(make_request(OP_REMOVE, 16'h5555, 32'h0));
    issue_request(make_request(OP_REMOVE, 16'hAAAA, 32'h0));
    issue_request(make_request(OP_SEARCH, 16'hAAAA, 32'h0));
    issue_request(make_request(OP_REMOVE, 16'h0000, 32'h0));
    issue_request(make_request(OP_REMOVE, 16'h0000, 32'h0));
    issue_request(make_request(OP_INSERT, 16'h0F0F, 32'hDEAD_BEEF));
    issue_request(make_request(OP_RANK, 16'h0, 32'h0));
    issue_request(make_request(OP_SEARCH, 16'h0F0F, 32'h0));
    issue_request(make_request(OP_REMOVE, 16'hFFFF, 32'h0));
    issue_request(make_request(OP_REMOVE, 16'hAAAA, 32'h0));
    issue_request(make_request(OP_REMOVE, 16'h0F0F, 32'h0));
    issue_request(make_request(OP_SEARCH, 16'hFFFF, 32'h0));
  endtask

  // Keys mostly name a live entry so that walks hit at every depth; a small
  // range makes duplicates, and full-width keys exercise every key bit.
  function automatic logic [KEY_W-1:0] choose_key();
    int sel;
    int idx;
    int cur;
    sel = $urandom_range(9);
    if (sel < 6 && live_count > 0) begin
      idx = $urandom_range(live_count - 1);
      cur = list_head;
      repeat (idx) cur = link_of[cur];
      return key_of[cur];
    end
    if (sel < 8) return KEY_W'($urandom_range(15));
    return KEY_W'($urandom());
  endfunction

  // Random traffic that swings the pool between empty and full: while filling,
  // inserts dominate until the pool is full and a few inserts have been refused;
  // then removals dominate until the list is empty again.
  task automatic test_random_traffic(input int count);
    request_t r;
    int pick;
    repeat (count) begin
      if (filling && live_count == SLOTS && $urandom_range(3) == 0) filling = 1'b0;
      else if (!filling && live_count == 0) filling = 1'b1;
      pick = $urandom_range(99);
      if (filling)
        r.op = (pick < 55) ? OP_INSERT : (pick < 70) ? OP_REMOVE :
               (pick < 94) ? OP_SEARCH : OP_RANK;
      else
        r.op = (pick < 15) ? OP_INSERT : (pick < 65) ? OP_REMOVE :
               (pick < 92) ? OP_SEARCH : OP_RANK;
      r.key = choose_key();
      r.payload = $urandom();
      issue_request(r);
    end
  endtask

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL array_linked_list_with_free_list");
    $finish;
  end

  initial begin
    clear_pool();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The sender first idles often, then very often, then never.
    sender_idle_pct = 36;
    test_empty_list();
    test_insert_search_rank();
    test_remove_cases();
    test_random_traffic(540);
    sender_idle_pct = 87;
    test_random_traffic(540);
    sender_idle_pct = 0;
    test_random_traffic(545);
    start <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (failed) begin
      $display("FAIL array_linked_list_with_free_list");
    end else begin
      $display("PASS array_linked_list_with_free_list");
    end
    $finish;
  end

endmodule
